// ===== rtl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the line pixel stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

	// default coordinate width
	localparam int COORD_BITS_DEF = 12;

	// operation codes of an input word
	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	// command handed from the input register to the stepper
	typedef struct packed {
		logic fire;
		op_t  op;
	} step_cmd_t;

endpackage : lps_pkg

`default_nettype wire

// ===== rtl/line_pixel_stepper_top.sv =====
// ----------------------------------------------------------------------------
// line_pixel_stepper_top
// Bresenham-style line stepper: a load word sets up a line, each advance
// word on an active line yields the next pixel with its mirrored screen row.
//
// Channel  Handshake                 Payload
// in       in_valid / in_stall       operation, x_start, y_start, x_end, y_end
// out      out_valid / out_stall     pixel_x, pixel_row, last_pixel
// cfg      cfg_valid / cfg_ready     cfg_data (window_height)
//
// One word per cycle while the output is not stalled; a pixel appears on the outputs
// after its advance word passes the input register, then the result register.
// The rate is set by the single error add and compare in the stepper.
// Reset clears the line state and the window height; no line is active.
// A stalled result holds its register; the input stage keeps accepting while
// the result register is empty or being taken. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pixel_stepper_top #(
	parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       operation,
	input  logic [COORD_BITS-1:0]      x_start,
	input  logic [COORD_BITS-1:0]      y_start,
	input  logic [COORD_BITS-1:0]      x_end,
	input  logic [COORD_BITS-1:0]      y_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [COORD_BITS-1:0]      pixel_x,
	output logic signed [COORD_BITS:0] pixel_row,
	output logic                       last_pixel,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [COORD_BITS-1:0]      cfg_data
);

	import lps_pkg::*;

	logic [COORD_BITS-1:0]     window_height_q;

	logic                      valid_s1;
	op_t                       op_s1;
	logic [COORD_BITS-1:0]     x_start_s1;
	logic [COORD_BITS-1:0]     y_start_s1;
	logic [COORD_BITS-1:0]     x_end_s1;
	logic [COORD_BITS-1:0]     y_end_s1;

	logic                      valid_s2;
	logic [COORD_BITS-1:0]     pixel_x_s2;
	logic signed [COORD_BITS:0] pixel_row_s2;
	logic                      last_pixel_s2;

	logic                      out_free;
	step_cmd_t                 cmd;

	logic [COORD_BITS-1:0]     first_x;
	logic [COORD_BITS-1:0]     first_y;
	logic [COORD_BITS-1:0]     major_end;
	logic [COORD_BITS-1:0]     major_len;
	logic [COORD_BITS-1:0]     minor_len;
	logic                      steep;
	logic                      minor_down;

	logic                      res_valid;
	logic [COORD_BITS-1:0]     res_x;
	logic signed [COORD_BITS:0] res_row;
	logic                      res_last;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_height_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			window_height_q <= cfg_data;
		end
	end

	// handshake: the input stage moves when the result register can take a word
	always_comb begin
		out_free = !valid_s2 || !out_stall;
		in_stall = valid_s1 && !out_free;
		cmd.fire = valid_s1 && out_free;
		cmd.op   = op_s1;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1      <= op_t'(operation);
			x_start_s1 <= x_start;
			y_start_s1 <= y_start;
			x_end_s1   <= x_end;
			y_end_s1   <= y_end;
		end
	end

	lps_line_setup #(
		.COORD_BITS (COORD_BITS)
	) u_setup (
		.x_start    (x_start_s1),
		.y_start    (y_start_s1),
		.x_end      (x_end_s1),
		.y_end      (y_end_s1),
		.first_x    (first_x),
		.first_y    (first_y),
		.major_end  (major_end),
		.major_len  (major_len),
		.minor_len  (minor_len),
		.steep      (steep),
		.minor_down (minor_down)
	);

	lps_stepper #(
		.COORD_BITS (COORD_BITS)
	) u_stepper (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.window_height (window_height_q),
		.first_x       (first_x),
		.first_y       (first_y),
		.major_end     (major_end),
		.major_len     (major_len),
		.minor_len     (minor_len),
		.steep         (steep),
		.minor_down    (minor_down),
		.res_valid     (res_valid),
		.res_x         (res_x),
		.res_row       (res_row),
		.res_last      (res_last)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			pixel_x_s2    <= res_x;
			pixel_row_s2  <= res_row;
			last_pixel_s2 <= res_last;
		end
	end

	assign out_valid  = valid_s2;
	assign pixel_x    = pixel_x_s2;
	assign pixel_row  = pixel_row_s2;
	assign last_pixel = last_pixel_s2;

	// a load word never produces a pixel
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fire && (cmd.op == OP_LOAD)) |=> !valid_s2)
		else $error("pixel emitted for a load word");

	// a word only moves to the stepper when the result register has room
	a_fire_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire |-> !(valid_s2 && out_stall))
		else $error("stepper fired into a blocked result register");

	// a blocked result register stalls a full input stage
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |=> valid_s1)
		else $error("input word lost while output stalled");

endmodule : line_pixel_stepper_top

`default_nettype wire

// ===== rtl/lps_line_setup.sv =====
// ----------------------------------------------------------------------------
// lps_line_setup
// Derives the stepping parameters of a new line from its two endpoints:
// major axis, absolute deltas, minor direction and the ordered start point.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_line_setup #(
	parameter int COORD_BITS = 12
) (
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic [COORD_BITS-1:0] first_x,
	output logic [COORD_BITS-1:0] first_y,
	output logic [COORD_BITS-1:0] major_end,
	output logic [COORD_BITS-1:0] major_len,
	output logic [COORD_BITS-1:0] minor_len,
	output logic                  steep,
	output logic                  minor_down
);

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [COORD_BITS:0] dx_abs;
	logic signed [COORD_BITS:0] dy_abs;
	logic [COORD_BITS-1:0]      adx;
	logic [COORD_BITS-1:0]      ady;
	logic                       swap;

	// signed deltas and their magnitudes
	always_comb begin
		dx     = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
		dy     = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
		dx_abs = dx[COORD_BITS] ? -dx : dx;
		dy_abs = dy[COORD_BITS] ? -dy : dy;
		adx    = dx_abs[COORD_BITS-1:0];
		ady    = dy_abs[COORD_BITS-1:0];
	end

	// pick the major axis; vertical and single-point lines step along y
	always_comb begin
		steep      = (dx == '0) || (ady > adx);
		minor_down = dx[COORD_BITS] != dy[COORD_BITS];
		swap       = steep ? (y_end < y_start) : (x_end < x_start);
		first_x    = swap ? x_end : x_start;
		first_y    = swap ? y_end : y_start;
		if (steep) begin
			major_end = swap ? y_start : y_end;
			major_len = ady;
			minor_len = adx;
		end else begin
			major_end = swap ? x_start : x_end;
			major_len = adx;
			minor_len = ady;
		end
	end

endmodule : lps_line_setup

`default_nettype wire

// ===== rtl/lps_stepper.sv =====
// ----------------------------------------------------------------------------
// lps_stepper
// Holds the line state and, per advance word, emits the current pixel and,
// short of the line end, takes one step with an exact integer error term.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_stepper #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lps_pkg::step_cmd_t           cmd,
	input  logic [COORD_BITS-1:0]        window_height,
	input  logic [COORD_BITS-1:0]        first_x,
	input  logic [COORD_BITS-1:0]        first_y,
	input  logic [COORD_BITS-1:0]        major_end,
	input  logic [COORD_BITS-1:0]        major_len,
	input  logic [COORD_BITS-1:0]        minor_len,
	input  logic                         steep,
	input  logic                         minor_down,
	output logic                         res_valid,
	output logic [COORD_BITS-1:0]        res_x,
	output logic signed [COORD_BITS:0]   res_row,
	output logic                         res_last
);

	import lps_pkg::*;

	localparam int ErrBits = COORD_BITS + 3;

	logic [COORD_BITS-1:0]     cur_x_q;
	logic [COORD_BITS-1:0]     cur_y_q;
	logic [COORD_BITS-1:0]     major_end_q;
	logic [COORD_BITS-1:0]     major_len_q;
	logic [COORD_BITS-1:0]     minor_len_q;
	logic signed [ErrBits-1:0] error_term_q;
	logic                      steep_mode_q;
	logic                      minor_down_q;
	logic                      line_active_q;

	logic [COORD_BITS-1:0]     major_pos;
	logic                      at_end;
	logic signed [ErrBits-1:0] err_sum;
	logic                      minor_move;
	logic [COORD_BITS-1:0]     minor_pos;
	logic [COORD_BITS-1:0]     minor_next;
	logic [COORD_BITS-1:0]     major_next;

	// current pixel and end check
	always_comb begin
		major_pos = steep_mode_q ? cur_y_q : cur_x_q;
		at_end    = major_pos == major_end_q;
		res_valid = cmd.fire && (cmd.op == OP_ADVANCE) && line_active_q;
		res_x     = cur_x_q;
		res_row   = $signed({1'b0, window_height}) - $signed({1'b0, cur_y_q});
		res_last  = at_end;
	end

	// error update and next coordinates
	always_comb begin
		err_sum    = error_term_q + $signed({2'b00, minor_len_q, 1'b0});
		minor_move = err_sum >= $signed({3'b000, major_len_q});
		minor_pos  = steep_mode_q ? cur_x_q : cur_y_q;
		minor_next = minor_down_q ? minor_pos - 1'b1 : minor_pos + 1'b1;
		major_next = major_pos + 1'b1;
	end

	// load a new line or advance the active one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			major_end_q   <= '0;
			major_len_q   <= '0;
			minor_len_q   <= '0;
			error_term_q  <= '0;
			steep_mode_q  <= 1'b0;
			minor_down_q  <= 1'b0;
			line_active_q <= 1'b0;
		end else if (cmd.fire) begin
			if (cmd.op == OP_LOAD) begin
				cur_x_q       <= first_x;
				cur_y_q       <= first_y;
				major_end_q   <= major_end;
				major_len_q   <= major_len;
				minor_len_q   <= minor_len;
				error_term_q  <= '0;
				steep_mode_q  <= steep;
				minor_down_q  <= minor_down;
				line_active_q <= 1'b1;
			end else if (line_active_q) begin
				if (at_end) begin
					line_active_q <= 1'b0;
				end else begin
					error_term_q <= minor_move
						? err_sum - $signed({2'b00, major_len_q, 1'b0}) : err_sum;
					if (steep_mode_q) begin
						cur_y_q <= major_next;
						if (minor_move) begin
							cur_x_q <= minor_next;
						end
					end else begin
						cur_x_q <= major_next;
						if (minor_move) begin
							cur_y_q <= minor_next;
						end
					end
				end
			end
		end
	end

	// error term stays within one major length of zero
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> (error_term_q >= -$signed({3'b000, major_len_q}))
			&& ((error_term_q < $signed({3'b000, major_len_q})) || (major_len_q == '0)))
		else $error("error term out of range");

	// minor delta never exceeds major delta
	a_minor_le_major: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> (minor_len_q <= major_len_q))
		else $error("minor delta exceeds major delta");

	// the end pixel retires the line
	a_last_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && at_end) |=> !line_active_q)
		else $error("line still active after its last pixel");

endmodule : lps_stepper

`default_nettype wire
